FILE: rtl/pva_pkg.sv
// Package for the polyphonic voice allocator.
// Holds opcodes, sequencer states, field widths and the note map request type.
// No dependencies.
package pva_pkg;

    localparam int VOICE_COUNT_DEF = 24;
    localparam int OP_W            = 2;
    localparam int NOTE_W          = 7;
    localparam int VEL_W           = 7;
    localparam int FIN_W           = 5;
    localparam int IDX_W           = 5;
    localparam int MASK_W          = 24;
    localparam int NOTE_DEPTH      = 1 << NOTE_W;

    typedef enum logic [OP_W-1:0] {
        OP_NOTE_ON  = 2'd0,
        OP_NOTE_OFF = 2'd1,
        OP_VOICE_FIN = 2'd2,
        OP_FREE_ALL = 2'd3
    } t_opcode;

    typedef enum logic [1:0] {
        S_IDLE,
        S_RD,
        S_CLR
    } t_state;

    typedef struct packed {
        logic              rd_en;
        logic [NOTE_W-1:0] rd_addr;
        logic              wr_en;
        logic [NOTE_W-1:0] wr_addr;
    } t_map_req;

endpackage

FILE: rtl/polyphonic_voice_allocator.sv
// Polyphonic voice allocator, top level: sequencer, active/gate masks, voice note store.
// Depends on pva_pkg and pva_note_map.
//
//   channel  | handshake              | fields
//   ---------+------------------------+-------------------------------------------------
//   command  | start, busy            | i_opcode, i_note_number, i_note_velocity,
//            |                        | i_finished_voice
//   result   | o_valid (one cycle)    | o_allocated, o_dropped, o_voice_index,
//            |                        | o_start_note, o_start_velocity, o_gate_off_mask,
//            |                        | o_active_mask
//
// Each item has a note map read, issued when it is accepted, then an update state that
// registers the result. A voice finished item on an active voice adds a clear state that
// removes that voice from its note's row, a second read-modify-write on the single note map port.
// The result strobe is registered from the update cycle, so it rises in the clear cycle if any.
// Synchronous reset clears masks, note map valid bits and the sequencer; no sweep.
// The receiver cannot stall; busy holds off new items while one is in flight.
module polyphonic_voice_allocator #(
    parameter int VOICE_COUNT = pva_pkg::VOICE_COUNT_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic [pva_pkg::OP_W-1:0]     i_opcode,
    input  logic [pva_pkg::NOTE_W-1:0]   i_note_number,
    input  logic [pva_pkg::VEL_W-1:0]    i_note_velocity,
    input  logic [pva_pkg::FIN_W-1:0]    i_finished_voice,
    output logic                         o_valid,
    output logic                         o_allocated,
    output logic                         o_dropped,
    output logic [pva_pkg::IDX_W-1:0]    o_voice_index,
    output logic [pva_pkg::NOTE_W-1:0]   o_start_note,
    output logic [pva_pkg::VEL_W-1:0]    o_start_velocity,
    output logic [pva_pkg::MASK_W-1:0]   o_gate_off_mask,
    output logic [pva_pkg::MASK_W-1:0]   o_active_mask
);

    localparam int VW = (VOICE_COUNT > 1) ? $clog2(VOICE_COUNT) : 1;

    pva_pkg::t_state  r_state, n_state;
    pva_pkg::t_map_req map_req;

    logic [VOICE_COUNT-1:0] r_active, n_active;
    logic [VOICE_COUNT-1:0] r_gate, n_gate;
    logic [VOICE_COUNT-1:0] map_wr_data, map_rd_data;

    // item registers
    pva_pkg::t_opcode            r_op;
    logic [pva_pkg::NOTE_W-1:0]  r_note;
    logic [pva_pkg::VEL_W-1:0]   r_vel;
    logic [VW-1:0]               r_fin_idx;
    logic                        r_fin_ok;

    // voice note store
    logic [pva_pkg::NOTE_W-1:0]  r_vnote_mem [VOICE_COUNT];
    logic [pva_pkg::NOTE_W-1:0]  r_vnote_q;
    logic                        vnote_wr;

    logic                        accept;
    logic [VW+pva_pkg::FIN_W-1:0] fin_pad;
    logic [VW-1:0]               fin_idx;
    logic                        fin_ok;
    logic                        free_found;
    logic [VW-1:0]               free_idx;
    logic [VOICE_COUNT-1:0]      free_bit, fin_bit;
    logic                        fin_live;

    logic                        r_valid, n_valid;
    logic                        r_alloc, n_alloc;
    logic                        r_drop, n_drop;
    logic [VW-1:0]               r_vidx, n_vidx;
    logic [pva_pkg::NOTE_W-1:0]  r_snote, n_snote;
    logic [pva_pkg::VEL_W-1:0]   r_svel, n_svel;
    logic [VOICE_COUNT-1:0]      r_goff, n_goff;

    logic [VOICE_COUNT+pva_pkg::MASK_W-1:0] goff_pad, act_pad;
    logic [VW+pva_pkg::IDX_W-1:0]           vidx_pad;

    assign busy    = (r_state != pva_pkg::S_IDLE);
    assign accept  = start && !busy;
    assign fin_pad = {{VW{1'b0}}, i_finished_voice};
    assign fin_idx = fin_pad[VW-1:0];
    assign fin_ok  = (32'(i_finished_voice) < 32'(VOICE_COUNT));

    // lowest inactive voice
    always_comb begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int i = VOICE_COUNT - 1; i >= 0; i--) begin
            if (!r_active[i]) begin
                free_found = 1'b1;
                free_idx   = VW'(i);
            end
        end
    end

    assign free_bit = {{(VOICE_COUNT-1){1'b0}}, 1'b1} << free_idx;
    assign fin_bit  = {{(VOICE_COUNT-1){1'b0}}, 1'b1} << r_fin_idx;
    assign fin_live = r_fin_ok && r_active[r_fin_idx];

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op      <= pva_pkg::t_opcode'(i_opcode);
            r_note    <= i_note_number;
            r_vel     <= i_note_velocity;
            r_fin_idx <= fin_idx;
            r_fin_ok  <= fin_ok;
        end
    end

    always_ff @(posedge i_clk) begin
        if (vnote_wr) begin
            r_vnote_mem[free_idx] <= r_note;
        end
        if (accept && fin_ok) begin
            r_vnote_q <= r_vnote_mem[fin_idx];
        end
    end

    pva_note_map #(
        .VOICE_COUNT(VOICE_COUNT)
    ) u_note_map (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (map_req),
        .i_wr_data (map_wr_data),
        .o_rd_data (map_rd_data)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            pva_pkg::S_IDLE: begin
                if (start) n_state = pva_pkg::S_RD;
            end
            pva_pkg::S_RD: begin
                if (r_op == pva_pkg::OP_VOICE_FIN && fin_live) n_state = pva_pkg::S_CLR;
                else n_state = pva_pkg::S_IDLE;
            end
            pva_pkg::S_CLR: n_state = pva_pkg::S_IDLE;
            default: n_state = pva_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        n_active        = r_active;
        n_gate          = r_gate;
        n_valid         = 1'b0;
        n_alloc         = 1'b0;
        n_drop          = 1'b0;
        n_vidx          = '0;
        n_snote         = '0;
        n_svel          = '0;
        n_goff          = '0;
        vnote_wr        = 1'b0;
        map_wr_data     = '0;
        map_req.rd_en   = 1'b0;
        map_req.rd_addr = i_note_number;
        map_req.wr_en   = 1'b0;
        map_req.wr_addr = r_note;
        unique case (r_state)
            pva_pkg::S_IDLE: begin
                map_req.rd_en = start;
            end
            pva_pkg::S_RD: begin
                n_valid = 1'b1;
                priority if (r_op == pva_pkg::OP_NOTE_ON && r_vel != '0) begin
                    if (free_found) begin
                        n_alloc       = 1'b1;
                        n_vidx        = free_idx;
                        n_snote       = r_note;
                        n_svel        = r_vel;
                        n_active      = r_active | free_bit;
                        n_gate        = r_gate | free_bit;
                        vnote_wr      = 1'b1;
                        map_req.wr_en = 1'b1;
                        map_wr_data   = map_rd_data | free_bit;
                    end else begin
                        n_drop = 1'b1;
                    end
                end else if (r_op == pva_pkg::OP_NOTE_ON || r_op == pva_pkg::OP_NOTE_OFF) begin
                    n_goff = map_rd_data & r_gate;
                    n_gate = r_gate & ~map_rd_data;
                end else if (r_op == pva_pkg::OP_VOICE_FIN) begin
                    if (fin_live) begin
                        n_active        = r_active & ~fin_bit;
                        map_req.rd_en   = 1'b1;
                        map_req.rd_addr = r_vnote_q;
                    end
                end else begin
                    n_goff = r_gate;
                    n_gate = '0;
                end
            end
            pva_pkg::S_CLR: begin
                map_req.wr_en   = 1'b1;
                map_req.wr_addr = r_vnote_q;
                map_wr_data     = map_rd_data & ~fin_bit;
            end
            default: begin
                n_valid = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= pva_pkg::S_IDLE;
            r_active <= '0;
            r_gate   <= '0;
            r_valid  <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_active <= n_active;
            r_gate   <= n_gate;
            r_valid  <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == pva_pkg::S_RD) begin
            r_alloc <= n_alloc;
            r_drop  <= n_drop;
            r_vidx  <= n_vidx;
            r_snote <= n_snote;
            r_svel  <= n_svel;
            r_goff  <= n_goff;
        end
    end

    assign goff_pad = {{pva_pkg::MASK_W{1'b0}}, r_goff};
    assign act_pad  = {{pva_pkg::MASK_W{1'b0}}, r_active};
    assign vidx_pad = {{pva_pkg::IDX_W{1'b0}}, r_vidx};

    assign o_valid          = r_valid;
    assign o_allocated      = r_alloc;
    assign o_dropped        = r_drop;
    assign o_voice_index    = vidx_pad[pva_pkg::IDX_W-1:0];
    assign o_start_note     = r_snote;
    assign o_start_velocity = r_svel;
    assign o_gate_off_mask  = goff_pad[pva_pkg::MASK_W-1:0];
    assign o_active_mask    = act_pad[pva_pkg::MASK_W-1:0];

    a_valid_after_rd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(r_state == pva_pkg::S_RD))
        else $error("result strobe without update cycle");

    a_alloc_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !(o_allocated && o_dropped))
        else $error("allocated and dropped together");

    a_alloc_no_goff: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_allocated) |-> (o_gate_off_mask == '0))
        else $error("gate cleared on allocation");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted item did not raise busy");

endmodule

FILE: rtl/pva_note_map.sv
// Note map: one row per note number, one bit per voice holding that note.
// Synchronous memory with a registered read and per-row valid bits.
// Depends on pva_pkg.
module pva_note_map #(
    parameter int VOICE_COUNT = pva_pkg::VOICE_COUNT_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  pva_pkg::t_map_req     i_req,
    input  logic [VOICE_COUNT-1:0] i_wr_data,
    output logic [VOICE_COUNT-1:0] o_rd_data
);

    logic [VOICE_COUNT-1:0]         r_mem [pva_pkg::NOTE_DEPTH];
    logic [pva_pkg::NOTE_DEPTH-1:0] r_vld;
    logic [VOICE_COUNT-1:0]         r_q;
    logic                           r_q_vld;

    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_mem[i_req.wr_addr] <= i_wr_data;
        end
        if (i_req.rd_en) begin
            r_q <= r_mem[i_req.rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld   <= '0;
            r_q_vld <= 1'b0;
        end else begin
            if (i_req.wr_en) begin
                r_vld[i_req.wr_addr] <= 1'b1;
            end
            if (i_req.rd_en) begin
                r_q_vld <= r_vld[i_req.rd_addr];
            end
        end
    end

    assign o_rd_data = r_q_vld ? r_q : '0;

endmodule

FILE: tb/sv/polyphonic_voice_allocator_test.sv
// Self-checking testbench for polyphonic_voice_allocator: directed voice-bank cases, then
// random note traffic under several sender idle rates, checked against an in-bench voice model.
// Depends on pva_pkg and the polyphonic_voice_allocator RTL.
module polyphonic_voice_allocator_test;

    localparam int VOICES = pva_pkg::VOICE_COUNT_DEF;

    typedef logic [pva_pkg::NOTE_W-1:0] t_note;
    typedef logic [pva_pkg::VEL_W-1:0]  t_vel;
    typedef logic [pva_pkg::FIN_W-1:0]  t_fin;
    typedef logic [pva_pkg::MASK_W-1:0] t_mask;

    typedef struct packed {
        logic                       allocated;
        logic                       dropped;
        logic [pva_pkg::IDX_W-1:0]  voice_index;
        logic [pva_pkg::NOTE_W-1:0] start_note;
        logic [pva_pkg::VEL_W-1:0]  start_velocity;
        logic [pva_pkg::MASK_W-1:0] gate_off_mask;
        logic [pva_pkg::MASK_W-1:0] active_mask;
    } t_bank_outcome;

    logic                         i_clk = 1'b0;
    logic                         i_rst_n = 1'b0;
    logic                         start = 1'b0;
    logic                         busy;
    logic [pva_pkg::OP_W-1:0]     i_opcode = '0;
    logic [pva_pkg::NOTE_W-1:0]   i_note_number = '0;
    logic [pva_pkg::VEL_W-1:0]    i_note_velocity = '0;
    logic [pva_pkg::FIN_W-1:0]    i_finished_voice = '0;
    logic                         o_valid;
    logic                         o_allocated;
    logic                         o_dropped;
    logic [pva_pkg::IDX_W-1:0]    o_voice_index;
    logic [pva_pkg::NOTE_W-1:0]   o_start_note;
    logic [pva_pkg::VEL_W-1:0]    o_start_velocity;
    logic [pva_pkg::MASK_W-1:0]   o_gate_off_mask;
    logic [pva_pkg::MASK_W-1:0]   o_active_mask;

    // voice bank as the testbench sees it
    logic [VOICES-1:0]            bank_active = '0;
    logic [VOICES-1:0]            bank_gate = '0;
    logic [pva_pkg::NOTE_W-1:0]   bank_note [VOICES];
    logic [pva_pkg::VEL_W-1:0]    bank_vel [VOICES];

    t_bank_outcome       awaited_outcomes [$];
    int                  fail_count = 0;

    polyphonic_voice_allocator dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .start            (start),
        .busy             (busy),
        .i_opcode         (i_opcode),
        .i_note_number    (i_note_number),
        .i_note_velocity  (i_note_velocity),
        .i_finished_voice (i_finished_voice),
        .o_valid          (o_valid),
        .o_allocated      (o_allocated),
        .o_dropped        (o_dropped),
        .o_voice_index    (o_voice_index),
        .o_start_note     (o_start_note),
        .o_start_velocity (o_start_velocity),
        .o_gate_off_mask  (o_gate_off_mask),
        .o_active_mask    (o_active_mask)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #3000000;
        $display("Verification failed");
        $finish;
    end

    function automatic t_bank_outcome advance_voice_bank(pva_pkg::t_opcode op,
                                                         logic [pva_pkg::NOTE_W-1:0] note,
                                                         logic [pva_pkg::VEL_W-1:0] vel,
                                                         logic [pva_pkg::FIN_W-1:0] fin);
        t_bank_outcome r;
        int            slot;
        r    = '0;
        slot = -1;
        if (op == pva_pkg::OP_NOTE_ON && vel != '0) begin
            for (int v = VOICES - 1; v >= 0; v--)
                if (!bank_active[v]) slot = v;
            if (slot >= 0) begin
                bank_active[slot] = 1'b1;
                bank_gate[slot]   = 1'b1;
                bank_note[slot]   = note;
                bank_vel[slot]    = vel;
                r.allocated       = 1'b1;
                r.voice_index     = slot[pva_pkg::IDX_W-1:0];
                r.start_note      = note;
                r.start_velocity  = vel;
            end else begin
                r.dropped = 1'b1;
            end
        end else if (op == pva_pkg::OP_NOTE_ON || op == pva_pkg::OP_NOTE_OFF) begin
            for (int v = 0; v < VOICES; v++) begin
                if (bank_active[v] && bank_note[v] == note) begin
                    r.gate_off_mask[v] = bank_gate[v];
                    bank_gate[v]       = 1'b0;
                end
            end
        end else if (op == pva_pkg::OP_VOICE_FIN) begin
            if (fin < VOICES) bank_active[fin] = 1'b0;
        end else begin
            r.gate_off_mask = bank_gate;
            bank_gate       = '0;
        end
        r.active_mask = bank_active;
        return r;
    endfunction

    task automatic send_event(pva_pkg::t_opcode op, logic [pva_pkg::NOTE_W-1:0] note,
                              logic [pva_pkg::VEL_W-1:0] vel,
                              logic [pva_pkg::FIN_W-1:0] fin);
        start            <= 1'b1;
        i_opcode         <= op;
        i_note_number    <= note;
        i_note_velocity  <= vel;
        i_finished_voice <= fin;
        do @(posedge i_clk); while (busy);
        awaited_outcomes.push_back(advance_voice_bank(op, note, vel, fin));
    endtask

    function automatic pva_pkg::t_opcode rand_opcode();
        return pva_pkg::t_opcode'($urandom_range(3));
    endfunction

    task automatic idle_cycle();
        start            <= 1'b0;
        i_opcode         <= rand_opcode();
        i_note_number    <= t_note'($urandom_range(127));
        i_note_velocity  <= t_vel'($urandom_range(127));
        i_finished_voice <= t_fin'($urandom_range(31));
        @(posedge i_clk);
    endtask

    task automatic drain_results();
        start <= 1'b0;
        @(posedge i_clk);
        while (awaited_outcomes.size() != 0) @(posedge i_clk);
    endtask

    task automatic check_field(string name, logic [pva_pkg::MASK_W-1:0] want,
                               logic [pva_pkg::MASK_W-1:0] got);
        if (want !== got) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge i_clk) begin : check_results
        t_bank_outcome want;
        if (i_rst_n && o_valid) begin
            if (awaited_outcomes.size() == 0) begin
                $error("result with no item outstanding");
                fail_count++;
            end else begin
                want = awaited_outcomes.pop_front();
                check_field("allocated", t_mask'(want.allocated), t_mask'(o_allocated));
                check_field("dropped", t_mask'(want.dropped), t_mask'(o_dropped));
                check_field("voice_index", t_mask'(want.voice_index), t_mask'(o_voice_index));
                check_field("start_note", t_mask'(want.start_note), t_mask'(o_start_note));
                check_field("start_velocity", t_mask'(want.start_velocity),
                            t_mask'(o_start_velocity));
                check_field("gate_off_mask", want.gate_off_mask, o_gate_off_mask);
                check_field("active_mask", want.active_mask, o_active_mask);
            end
        end
    end

    task automatic test_release_on_empty_bank();
        send_event(pva_pkg::OP_NOTE_OFF, 7'd0, 7'd0, 5'd0);
    endtask

    // voices 0/1 carry the note and velocity extremes, 2..3 share note 60; bank ends full
    task automatic test_fill_and_drop();
        logic [pva_pkg::NOTE_W-1:0] note;
        logic [pva_pkg::VEL_W-1:0]  vel;
        for (int v = 0; v < VOICES; v++) begin
            note = (v == 0) ? 7'd127 : (v == 1) ? 7'd0 : (v < 4) ? 7'd60 : t_note'(v * 5);
            vel  = (v == 0) ? 7'd127 : (v == 1) ? 7'd1 : t_vel'(v * 5);
            send_event(pva_pkg::OP_NOTE_ON, note, vel, t_fin'($urandom_range(31)));
        end
        send_event(pva_pkg::OP_NOTE_ON, 7'd64, 7'd100, 5'd0);
    endtask

    task automatic test_zero_velocity_release();
        send_event(pva_pkg::OP_NOTE_ON, 7'd60, 7'd0, 5'd0);
        send_event(pva_pkg::OP_NOTE_OFF, 7'd60, 7'd0, 5'd0);
    endtask

    task automatic test_voice_finished();
        send_event(pva_pkg::OP_VOICE_FIN, 7'd0, 7'd0, 5'd23);
        send_event(pva_pkg::OP_VOICE_FIN, 7'd0, 7'd0, 5'd24);
        send_event(pva_pkg::OP_VOICE_FIN, 7'd127, 7'd127, 5'd31);
    endtask

    // voice 23 is inactive but still gated
    task automatic test_reused_voice();
        send_event(pva_pkg::OP_NOTE_ON, 7'd127, 7'd127, 5'd0);
    endtask

    task automatic test_free_all();
        send_event(pva_pkg::OP_FREE_ALL, 7'd0, 7'd0, 5'd0);
        send_event(pva_pkg::OP_FREE_ALL, 7'd127, 7'd127, 5'd31);
    endtask

    task automatic test_random_traffic(int idle_pct, int count);
        int                         roll;
        int                         pick;
        pva_pkg::t_opcode           op;
        logic [pva_pkg::NOTE_W-1:0] note;
        logic [pva_pkg::VEL_W-1:0]  vel;
        logic [pva_pkg::FIN_W-1:0]  fin;
        for (int n = 0; n < count; n++) begin
            while ($urandom_range(99) < idle_pct) idle_cycle();
            roll = $urandom_range(99);
            pick = $urandom_range(VOICES - 1);
            note = t_note'($urandom_range(127));
            vel  = t_vel'($urandom_range(127, 1));
            fin  = t_fin'($urandom_range(31));
            if (roll < 10) begin
                op  = rand_opcode();
                vel = t_vel'($urandom_range(127));
            end else if (roll < 50) begin
                op = pva_pkg::OP_NOTE_ON;
                if ($urandom_range(1)) note = t_note'(60 + $urandom_range(3));
            end else if (roll < 70) begin
                op = $urandom_range(1) ? pva_pkg::OP_NOTE_OFF : pva_pkg::OP_NOTE_ON;
                if (op == pva_pkg::OP_NOTE_ON) vel = '0;
                if (bank_active[pick]) note = bank_note[pick];
            end else if (roll < 97) begin
                op = pva_pkg::OP_VOICE_FIN;
                if ($urandom_range(7) != 0) fin = t_fin'(pick);
            end else begin
                op = pva_pkg::OP_FREE_ALL;
            end
            send_event(op, note, vel, fin);
        end
        drain_results();
    endtask

    initial begin
        for (int v = 0; v < VOICES; v++) begin
            bank_note[v] = '0;
            bank_vel[v]  = '0;
        end
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_release_on_empty_bank();
        test_fill_and_drop();
        test_zero_velocity_release();
        test_voice_finished();
        test_reused_voice();
        test_free_all();
        drain_results();

        test_random_traffic(0, 310);
        test_random_traffic(88, 310);
        test_random_traffic(0, 310);
        test_random_traffic(9, 310);

        repeat (8) @(posedge i_clk);
        if (fail_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

FILE: sim.f
rtl/pva_pkg.sv
rtl/pva_note_map.sv
rtl/polyphonic_voice_allocator.sv
tb/sv/polyphonic_voice_allocator_test.sv
